/* design/ssmt_pkg.sv */
`timescale 1ns / 1ps

package ssmt_pkg;

    // Item kinds carried on s_tuser
    localparam logic REQ_SET  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_SLOT_TICKS  = 2'd0;
    localparam logic [1:0] CFG_SEG_LOW_LIT = 2'd1;
    localparam logic [1:0] CFG_DIG_HIGH_EN = 2'd2;

    localparam logic [15:0] SLOT_TICKS_RESET = 16'd1000;

    // Clamp limit in hundredths (99.9 degrees)
    localparam logic signed [15:0] TEMP_MAX = 16'sd9990;

    localparam int NUM_DIGITS = 3;

    // Segments A..G, bit 0 is A
    typedef logic [6:0] seg_pat_t;

    typedef struct packed {
        seg_pat_t d2;   // tenths
        seg_pat_t d1;   // ones
        seg_pat_t d0;   // tens
    } digits_t;

    // Logical latch contents: 1 means lit / enabled
    typedef struct packed {
        logic [7:0] seg;
        logic [2:0] dig;
    } latch_t;

    // Fixed digit font
    function automatic seg_pat_t font(input logic [3:0] d);
        seg_pat_t p;
        case (d)
            4'd0:    p = 7'b0111111;
            4'd1:    p = 7'b0000110;
            4'd2:    p = 7'b1011011;
            4'd3:    p = 7'b1001111;
            4'd4:    p = 7'b1100110;
            4'd5:    p = 7'b1101101;
            4'd6:    p = 7'b1111101;
            4'd7:    p = 7'b0000111;
            4'd8:    p = 7'b1111111;
            4'd9:    p = 7'b1101111;
            default: p = 7'b0000000;
        endcase
        return p;
    endfunction

endpackage

/* design/seven_segment_mux_temperature_top.sv */
`timescale 1ns / 1ps

// Three-digit multiplexed seven-segment driver showing a temperature as XX.X.
// A set word (tuser 0) carries hundredths of a degree plus a leading-zero
// blank flag; a tick word (tuser 1) stands for one microsecond and moves the
// scan on to the next digit every slot_ticks ticks. Every word returns one
// result word holding the segment and digit pin levels after it is handled,
// with polarity applied from the configuration registers. One word is taken
// per clock: the temperature split and font lookup are one pass of logic
// into the scan registers, and the result sits in a single output register,
// so a result comes out in the cycle after its word and s_tready only drops
// while that register holds a result that m_tready has not taken.
module seven_segment_mux_temperature_top (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // temp_hundredths[15:0], blank_zero[16], zero pad
    input  logic        s_tuser,   // req_type
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // segment_lines[7:0], digit_lines[10:8], zero pad
);

    logic [15:0]       slot_ticks_reg;
    logic              seg_low_lit_reg;
    logic              dig_high_en_reg;
    logic              out_valid_reg;
    logic [7:0]        seg_out_reg;
    logic [2:0]        dig_out_reg;
    logic              word_in;
    ssmt_pkg::digits_t digits;
    ssmt_pkg::latch_t  latch, latch_next;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_ticks_reg  <= ssmt_pkg::SLOT_TICKS_RESET;
            seg_low_lit_reg <= 1'b0;
            dig_high_en_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ssmt_pkg::CFG_SLOT_TICKS:  slot_ticks_reg  <= cfg_data;
                ssmt_pkg::CFG_SEG_LOW_LIT: seg_low_lit_reg <= cfg_data[0];
                ssmt_pkg::CFG_DIG_HIGH_EN: dig_high_en_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign s_tready = !out_valid_reg || m_tready;
    assign word_in  = s_tvalid && s_tready;

    ssmt_digit_fmt u_fmt (
        .temp_hundredths (s_tdata[15:0]),
        .blank_zero      (s_tdata[16]),
        .digits          (digits)
    );

    ssmt_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .word_en    (word_in),
        .req_type   (s_tuser),
        .digits_in  (digits),
        .slot_ticks (slot_ticks_reg),
        .latch      (latch),
        .latch_next (latch_next)
    );

    // Result register, pin polarity applied on load
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (word_in) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (word_in) begin
            seg_out_reg <= seg_low_lit_reg ? ~latch_next.seg : latch_next.seg;
            dig_out_reg <= dig_high_en_reg ? latch_next.dig : ~latch_next.dig;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, dig_out_reg, seg_out_reg};

    // At most one digit enabled at any time
    a_one_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(latch.dig))
        else $error("more than one digit enabled");

    // An accepted word always yields a result next cycle
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        word_in |=> m_tvalid)
        else $error("accepted word produced no result");

    // A set word never changes the latches
    a_set_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (word_in && (s_tuser == ssmt_pkg::REQ_SET)) |=> (latch == $past(latch)))
        else $error("set word changed the latches");

    // Point lit only with the first digit
    a_point: assert property (@(posedge aclk) disable iff (!aresetn)
        latch.seg[7] |-> (latch.dig == 3'b001))
        else $error("decimal point lit away from first digit");

endmodule

/* design/ssmt_digit_fmt.sv */
`timescale 1ns / 1ps

module ssmt_digit_fmt (
    input  logic signed [15:0] temp_hundredths,
    input  logic               blank_zero,
    output ssmt_pkg::digits_t  digits
);

    logic [13:0] clamped;
    logic [13:0] x;
    logic [29:0] prod10;
    logic [26:0] prod100;
    logic [27:0] prod1000;
    logic [9:0]  q10;
    logic [6:0]  q100;
    logic [3:0]  q1000;
    logic [9:0]  tenths_w;
    logic [6:0]  ones_w;

    // Clamp to 0..9990, then add the rounding half
    always_comb begin
        if (temp_hundredths[15]) begin
            clamped = 14'd0;
        end else if (temp_hundredths > ssmt_pkg::TEMP_MAX) begin
            clamped = 14'(ssmt_pkg::TEMP_MAX);
        end else begin
            clamped = temp_hundredths[13:0];
        end
        x = clamped + 14'd5;
    end

    // Reciprocal multiplies, exact for x below 10000
    assign prod10   = 30'(x) * 30'd52429;   // x / 10
    assign prod100  = 27'(x) * 27'd5243;    // x / 100
    assign prod1000 = 28'(x) * 28'd8389;    // x / 1000

    assign q10   = prod10[28:19];
    assign q100  = prod100[25:19];
    assign q1000 = prod1000[26:23];

    // Remainders by shift-add times ten
    assign tenths_w = q10 - ({3'd0, q100} << 3) - ({3'd0, q100} << 1);
    assign ones_w   = q100 - ({3'd0, q1000} << 3) - ({3'd0, q1000} << 1);

    // Font lookup; leading zero optionally blanked
    always_comb begin
        if (blank_zero && (q1000 == 4'd0)) begin
            digits.d0 = '0;
        end else begin
            digits.d0 = ssmt_pkg::font(q1000);
        end
        digits.d1 = ssmt_pkg::font(ones_w[3:0]);
        digits.d2 = ssmt_pkg::font(tenths_w[3:0]);
    end

endmodule

/* design/ssmt_scan.sv */
`timescale 1ns / 1ps

module ssmt_scan (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              word_en,
    input  logic              req_type,
    input  ssmt_pkg::digits_t digits_in,
    input  logic [15:0]       slot_ticks,
    output ssmt_pkg::latch_t  latch,
    output ssmt_pkg::latch_t  latch_next
);

    logic [15:0]       slot_count_reg, slot_count_next;
    logic [1:0]        active_digit_reg, active_digit_next;
    ssmt_pkg::digits_t patterns_reg, patterns_next;
    logic              point_reg, point_next;
    ssmt_pkg::latch_t  latch_reg;
    logic [15:0]       count_inc;

    assign count_inc = slot_count_reg + 16'd1;

    // Tick counting, digit advance and pattern updates
    always_comb begin
        slot_count_next   = slot_count_reg;
        active_digit_next = active_digit_reg;
        patterns_next     = patterns_reg;
        point_next        = point_reg;
        latch_next        = latch_reg;
        if (word_en) begin
            if (req_type == ssmt_pkg::REQ_TICK) begin
                slot_count_next = count_inc;
                if (count_inc >= slot_ticks) begin
                    slot_count_next = 16'd0;
                    unique case (active_digit_reg)
                        2'd0: begin
                            active_digit_next = 2'd1;
                            latch_next.seg    = {1'b0, patterns_reg.d1};
                            latch_next.dig    = 3'b010;
                        end
                        2'd1: begin
                            active_digit_next = 2'd2;
                            latch_next.seg    = {1'b0, patterns_reg.d2};
                            latch_next.dig    = 3'b100;
                        end
                        default: begin
                            active_digit_next = 2'd0;
                            latch_next.seg    = {point_reg, patterns_reg.d0};
                            latch_next.dig    = 3'b001;
                        end
                    endcase
                end
            end else begin
                patterns_next = digits_in;
                point_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_count_reg   <= '0;
            active_digit_reg <= '0;
            patterns_reg     <= '0;
            point_reg        <= 1'b0;
            latch_reg        <= '0;
        end else begin
            slot_count_reg   <= slot_count_next;
            active_digit_reg <= active_digit_next;
            patterns_reg     <= patterns_next;
            point_reg        <= point_next;
            latch_reg        <= latch_next;
        end
    end

    assign latch = latch_reg;

endmodule

/* tb/sv/ssmt_tb_pkg.sv */
`timescale 1ns / 1ps

package ssmt_tb_pkg;

    import ssmt_pkg::*;

    // Pin levels carried by one result word
    typedef struct packed {
        logic [7:0] seg;
        logic [2:0] dig;
    } pin_levels_t;

    // Tracks the scan state of the display and the pin levels each word should leave
    class pin_level_model;

        // configuration
        logic [15:0] slot_ticks;
        logic        seg_low_lit;
        logic        dig_high_en;

        // scan state, latches hold logical on/off
        logic [15:0] slot_count;
        logic [1:0]  active_digit;
        logic [6:0]  pattern [NUM_DIGITS];
        logic        point_on_first;
        logic [7:0]  seg_latch;
        logic [2:0]  dig_latch;

        logic [6:0]  glyph [10];
        pin_levels_t expected_pins [$];
        int          failures;

        function new();
            glyph = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F};
            slot_ticks      = SLOT_TICKS_RESET;
            seg_low_lit     = 1'b0;
            dig_high_en     = 1'b1;
            slot_count      = '0;
            active_digit    = '0;
            foreach (pattern[i]) pattern[i] = '0;
            point_on_first  = 1'b0;
            seg_latch       = '0;
            dig_latch       = '0;
            failures        = 0;
        endfunction

        // Unknown indexes fall through and change nothing
        function void apply_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                CFG_SLOT_TICKS:  slot_ticks = val;
                CFG_SEG_LOW_LIT: seg_low_lit = val[0];
                CFG_DIG_HIGH_EN: dig_high_en = val[0];
                default: ;
            endcase
        endfunction

        // Update the scan state for one accepted word and queue the pins it leaves
        function void note_word(logic kind, logic signed [15:0] temp, logic blank);
            int v, r, tens, ones, tenths;
            pin_levels_t pins;
            if (kind == REQ_TICK) begin
                slot_count = slot_count + 16'd1;
                // >= so that a zero slot or a shortened one advances at once
                if (slot_count >= slot_ticks) begin
                    slot_count   = '0;
                    active_digit = (active_digit == 2'd2) ? 2'd0 : active_digit + 2'd1;
                    seg_latch    = {1'b0, pattern[active_digit]};
                    if (active_digit == 2'd0 && point_on_first) seg_latch[7] = 1'b1;
                    dig_latch    = 3'b001 << active_digit;
                end
            end else begin
                v = temp;
                if (v < 0) v = 0;
                if (v > 9990) v = 9990;
                r      = (v + 5) / 10;
                tens   = r / 100;
                ones   = (r / 10) % 10;
                tenths = r % 10;
                if (tens > 9) tens = 9;
                pattern[0] = (tens == 0 && blank) ? 7'd0 : glyph[tens];
                pattern[1] = glyph[ones];
                pattern[2] = glyph[tenths];
                point_on_first = 1'b1;
            end
            // polarity is applied at the pins, not in the latches
            pins.seg = seg_low_lit ? ~seg_latch : seg_latch;
            pins.dig = dig_high_en ? dig_latch : ~dig_latch;
            expected_pins.push_back(pins);
        endfunction

        function void check_pins(logic [15:0] data);
            pin_levels_t want;
            if (expected_pins.size() == 0) begin
                $error("unexpected result word: segment_lines %h digit_lines %h",
                       data[7:0], data[10:8]);
                failures++;
                return;
            end
            want = expected_pins.pop_front();
            if (data[7:0] !== want.seg) begin
                $error("segment_lines: expected %h, got %h", want.seg, data[7:0]);
                failures++;
            end
            if (data[10:8] !== want.dig) begin
                $error("digit_lines: expected %h, got %h", want.dig, data[10:8]);
                failures++;
            end
        endfunction

        function int pending();
            return expected_pins.size();
        endfunction

    endclass

endpackage

/* tb/sv/tb_seven_segment_mux_temperature_top.sv */
`timescale 1ns / 1ps

module tb_seven_segment_mux_temperature_top;

    import ssmt_pkg::*;
    import ssmt_tb_pkg::*;

    // index with no register behind it
    localparam logic [1:0] CFG_UNUSED  = 2'd3;
    localparam int         HOLD_CYCLES = 64;
    localparam int         PHASES      = 8;
    localparam int         PHASE_WORDS = 100;

    // corner temperatures for the directed part, blank flag alongside
    localparam logic [15:0] CORNER_TEMP [10] = '{
        16'h8000, 16'h7FFF, 16'd0, 16'd4, 16'd5,
        16'd99, 16'd995, 16'd9985, 16'd9994, 16'hFFFF
    };
    localparam logic [9:0]  CORNER_BLANK = 10'b1000100110;

    localparam logic [15:0] SLOT_PLAN [PHASES] = '{
        16'd1, 16'd2, 16'd0, 16'd3, 16'd65535, 16'd2, 16'd1, 16'd5
    };

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // temp_hundredths[15:0], blank_zero[16], zero pad
    logic        s_tuser;   // req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // segment_lines[7:0], digit_lines[10:8], zero pad

    int snd_idle_pct;
    int rcv_stall_pct;
    int hold_requests;

    pin_level_model model;

    seven_segment_mux_temperature_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("seven_segment_mux_temperature_top regression: fail");
        $finish;
    end

    // Watch both channels; values seen here are the ones before the edge
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) model.check_pins(m_tdata);
        if (aresetn && s_tvalid && s_tready)
            model.note_word(s_tuser, s_tdata[15:0], s_tdata[16]);
    end

    // Receiver: random stalls, plus a long hold-off when asked for
    initial begin
        int hold_left;
        int holds_seen;
        hold_left  = 0;
        holds_seen = 0;
        m_tready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_requests != holds_seen) begin
                holds_seen = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= rcv_stall_pct);
            end
        end
    end

    task automatic program_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        model.apply_reg(idx, val);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Offer one word, with random idle cycles ahead of it; returns on acceptance
    task automatic send_word(input logic kind, input logic [15:0] temp, input logic blank);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, blank, temp};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_random_word();
        logic [15:0] temp;
        logic        blank;
        temp  = 16'($urandom);
        blank = 1'($urandom_range(1));
        if ($urandom_range(99) < 65) begin
            send_word(REQ_TICK, temp, blank);
        end else begin
            case ($urandom_range(3))
                0: ;    // full 16-bit range
                1, 2: temp = 16'(int'($urandom_range(10100)) - 50);
                default: begin
                    // around the clamp limits and the rounding step
                    if ($urandom_range(1)) temp = 16'(9980 + int'($urandom_range(20)));
                    else temp = 16'(int'($urandom_range(20)) - 5);
                end
            endcase
            send_word(REQ_SET, temp, blank);
        end
    endtask

    // Stop offering and wait until every expected word is back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (model.pending() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    initial begin
        model         = new();
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = REQ_SET;
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        hold_requests = 0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset slot length: ticks alone, nothing lit yet
        repeat (5) send_word(REQ_TICK, 16'h0000, 1'b0);
        drain();
        // slot shortened below the running count, next tick advances
        program_reg(CFG_SLOT_TICKS, 16'd3);
        send_word(REQ_TICK, 16'hFFFF, 1'b1);
        drain();
        // zero slot acts as one; walk the corner temperatures
        program_reg(CFG_SLOT_TICKS, 16'd0);
        foreach (CORNER_TEMP[i]) begin
            send_word(REQ_SET, CORNER_TEMP[i], CORNER_BLANK[i]);
            send_word(REQ_TICK, ~CORNER_TEMP[i], ~CORNER_BLANK[i]);
        end
        drain();
        // write to an index with no register; slot length must stay zero
        program_reg(CFG_UNUSED, 16'hFFFF);
        repeat (3) send_word(REQ_TICK, 16'h5A5A, 1'b0);
        drain();

        // random phases across slot lengths, polarities and idling modes
        for (int p = 0; p < PHASES; p++) begin
            program_reg(CFG_SLOT_TICKS, SLOT_PLAN[p]);
            program_reg(CFG_SEG_LOW_LIT, {15'd0, p[0]});
            program_reg(CFG_DIG_HIGH_EN, {15'd0, ~p[1]});
            case (p % 4)
                0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin snd_idle_pct = 82; rcv_stall_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_stall_pct = 82; end
                default: begin snd_idle_pct = 19; rcv_stall_pct = 19; end
            endcase
            for (int i = 0; i < PHASE_WORDS; i++) begin
                // long receiver hold-off while words keep coming
                if (p == 0 && i == 20) hold_requests++;
                // sender pause until everything is back
                if (p == 5 && i == 50) drain();
                send_random_word();
            end
            drain();
        end

        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        drain();
        repeat (10) @(posedge aclk);
        if (model.failures == 0 && model.pending() == 0) begin
            $display("seven_segment_mux_temperature_top regression: pass");
        end else begin
            $display("seven_segment_mux_temperature_top regression: fail");
        end
        $finish;
    end

endmodule

/* seven_segment_mux_temperature_top.f */
design/ssmt_pkg.sv
design/ssmt_digit_fmt.sv
design/ssmt_scan.sv
design/seven_segment_mux_temperature_top.sv
tb/sv/ssmt_tb_pkg.sv
tb/sv/tb_seven_segment_mux_temperature_top.sv
